/* rtl/utf8_validator_assert.svh */
// ----------------------------------------------------------------------------
// utf8_validator assertion macros
// shared concurrent assertion forms for the utf8 validator
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATOR_ASSERT_SVH
`define UTF8_VALIDATOR_ASSERT_SVH

// same-cycle implication
`define UTF8V_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UTF8V_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/utf8v_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_pkg
// types and byte-range constants of the utf8 validator
// ----------------------------------------------------------------------------
package utf8v_pkg;

   typedef enum logic [2:0] {
      KIND_PLAIN = 3'd0,
      KIND_E0    = 3'd1,
      KIND_ED    = 3'd2,
      KIND_F0    = 3'd3,
      KIND_F4    = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_RUNNING = 2'd0,
      ST_VALID   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0] pend;
      kind_type   kind;
      logic       err;
   } state_type;

   typedef struct packed {
      status_type status;
      logic       done;
   } result_type;

   localparam state_type STATE_RESET = '{pend: 2'd0, kind: KIND_PLAIN, err: 1'b0};

   localparam logic [7:0] ASCII_HI   = 8'h7F;
   localparam logic [7:0] LEAD2_LO   = 8'hC2;
   localparam logic [7:0] LEAD2_HI   = 8'hDF;
   localparam logic [7:0] LEAD_E0    = 8'hE0;
   localparam logic [7:0] LEAD_ED    = 8'hED;
   localparam logic [7:0] LEAD_F0    = 8'hF0;
   localparam logic [7:0] LEAD_F4    = 8'hF4;
   localparam logic [7:0] CONT_LO    = 8'h80;
   localparam logic [7:0] CONT_HI    = 8'hBF;
   localparam logic [7:0] CONT_E0_LO = 8'hA0;
   localparam logic [7:0] CONT_ED_HI = 8'h9F;
   localparam logic [7:0] CONT_F0_LO = 8'h90;
   localparam logic [7:0] CONT_F4_HI = 8'h8F;

endpackage

/* rtl/utf8v_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_req_if / utf8v_rsp_if
// valid/ready channels for input bytes and status results
// ----------------------------------------------------------------------------
interface utf8v_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic       string_done;

   modport source (output valid, output status, output string_done, input ready);
   modport sink   (input valid, input status, input string_done, output ready);
endinterface

/* rtl/utf8_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validator
// strict utf-8 checker (nul forbidden), one status result per input byte
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns one result per byte: a running status,
// or on the byte flagged last the final verdict, after which the checker state
// clears for the next string. Throughput is one byte every cycle until a
// stalled output fills the result buffer; a byte's result passes the input
// register, then the result register, set by the single state-update step
// between them. The two-entry buffer keeps input flowing while a result waits.
// ----------------------------------------------------------------------------
`include "utf8_validator_assert.svh"

module utf8_validator (
   input  logic              clock,
   input  logic              reset,
   utf8v_req_if.sink         req_chan,
   utf8v_rsp_if.source       rsp_chan
);

   // input register
   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [7:0]            s1_byte_ff;
   logic                  s1_last_ff;
   logic                  s1_move;
   logic                  req_take;

   // checker state
   utf8v_pkg::state_type  state_ff;
   utf8v_pkg::state_type  state_in;
   utf8v_pkg::state_type  step_state;
   utf8v_pkg::result_type step_result;

   // result register and skid
   logic                  out_valid_ff;
   logic                  out_valid_in;
   utf8v_pkg::result_type out_ff;
   utf8v_pkg::result_type out_in;
   logic                  skid_valid_ff;
   logic                  skid_valid_in;
   utf8v_pkg::result_type skid_ff;
   utf8v_pkg::result_type skid_in;
   logic                  out_free;

   utf8v_step u_step (
      .cur_state (state_ff),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .nxt_state (step_state),
      .result    (step_result)
   );

   assign s1_move          = s1_valid_ff && !skid_valid_ff;
   assign req_chan.ready   = !s1_valid_ff || !skid_valid_ff;
   assign req_take         = req_chan.valid && req_chan.ready;
   assign out_free         = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      s1_valid_in = req_take || (s1_valid_ff && !s1_move);
      state_in    = s1_move ? step_state : state_ff;

      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (s1_move) begin
            out_in       = step_result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (s1_move) begin
         skid_in       = step_result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         state_ff      <= utf8v_pkg::STATE_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_ff.status;
   assign rsp_chan.string_done = out_ff.done;

   `UTF8V_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid holds a result while the result register is empty")

   `UTF8V_ASSERT_NOW(a_verdict_final, clock, reset,
      out_valid_ff && out_ff.done,
      out_ff.status == utf8v_pkg::ST_VALID || out_ff.status == utf8v_pkg::ST_INVALID,
      "final verdict carries a running status")

   `UTF8V_ASSERT_NEXT(a_last_clears, clock, reset, s1_move && s1_last_ff,
      state_ff == utf8v_pkg::STATE_RESET,
      "checker state not cleared after the last byte")

   `UTF8V_ASSERT_NEXT(a_error_sticky, clock, reset,
      state_ff.err && !(s1_move && s1_last_ff), state_ff.err,
      "error flag dropped inside a string")

endmodule

/* rtl/utf8v_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8v_step
// one-byte update of the utf8 checker state and its status result
// ----------------------------------------------------------------------------
module utf8v_step (
   input  utf8v_pkg::state_type  cur_state,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output utf8v_pkg::state_type  nxt_state,
   output utf8v_pkg::result_type result
);

   logic [7:0] cont_lo;
   logic [7:0] cont_hi;
   logic       cont_ok;

   always_comb begin
      cont_lo = utf8v_pkg::CONT_LO;
      cont_hi = utf8v_pkg::CONT_HI;
      case (cur_state.kind)
         utf8v_pkg::KIND_E0: begin
            cont_lo = utf8v_pkg::CONT_E0_LO;
         end
         utf8v_pkg::KIND_ED: begin
            cont_hi = utf8v_pkg::CONT_ED_HI;
         end
         utf8v_pkg::KIND_F0: begin
            cont_lo = utf8v_pkg::CONT_F0_LO;
         end
         utf8v_pkg::KIND_F4: begin
            cont_hi = utf8v_pkg::CONT_F4_HI;
         end
         default: begin
         end
      endcase
      cont_ok = (data_byte >= cont_lo) && (data_byte <= cont_hi);
   end

   always_comb begin
      nxt_state = cur_state;
      if (!cur_state.err) begin
         if (cur_state.pend == 2'd0) begin
            case (data_byte) inside
               8'h00: begin
                  nxt_state.err = 1'b1;
               end
               [8'h01:utf8v_pkg::ASCII_HI]: begin
               end
               [utf8v_pkg::LEAD2_LO:utf8v_pkg::LEAD2_HI]: begin
                  nxt_state.pend = 2'd1;
                  nxt_state.kind = utf8v_pkg::KIND_PLAIN;
               end
               utf8v_pkg::LEAD_E0: begin
                  nxt_state.pend = 2'd2;
                  nxt_state.kind = utf8v_pkg::KIND_E0;
               end
               utf8v_pkg::LEAD_ED: begin
                  nxt_state.pend = 2'd2;
                  nxt_state.kind = utf8v_pkg::KIND_ED;
               end
               [8'hE1:8'hEF]: begin
                  nxt_state.pend = 2'd2;
                  nxt_state.kind = utf8v_pkg::KIND_PLAIN;
               end
               utf8v_pkg::LEAD_F0: begin
                  nxt_state.pend = 2'd3;
                  nxt_state.kind = utf8v_pkg::KIND_F0;
               end
               [8'hF1:8'hF3]: begin
                  nxt_state.pend = 2'd3;
                  nxt_state.kind = utf8v_pkg::KIND_PLAIN;
               end
               utf8v_pkg::LEAD_F4: begin
                  nxt_state.pend = 2'd3;
                  nxt_state.kind = utf8v_pkg::KIND_F4;
               end
               default: begin
                  nxt_state.err = 1'b1;
               end
            endcase
         end else if (cont_ok) begin
            nxt_state.pend = cur_state.pend - 2'd1;
            nxt_state.kind = utf8v_pkg::KIND_PLAIN;
         end else begin
            nxt_state.err = 1'b1;
         end
      end

      if (last_byte) begin
         result.status = (nxt_state.err || (nxt_state.pend != 2'd0)) ?
                         utf8v_pkg::ST_INVALID : utf8v_pkg::ST_VALID;
         result.done   = 1'b1;
         nxt_state     = utf8v_pkg::STATE_RESET;
      end else begin
         result.status = nxt_state.err ? utf8v_pkg::ST_INVALID : utf8v_pkg::ST_RUNNING;
         result.done   = 1'b0;
      end
   end

endmodule
